/* rtl/rdsh_pkg.sv */
// ----------------------------------------------------------------------------
// rdsh_pkg
// Types and constants shared by the ray and disc shield hit scan block.
// ----------------------------------------------------------------------------
package rdsh_pkg;

	localparam int FRAC_BITS = 16;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 33;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int CNT_W   = $clog2(MUL_A_W);

	typedef struct packed {
		logic signed [31:0] atom_x;
		logic signed [31:0] atom_y;
		logic signed [31:0] atom_z;
		logic signed [31:0] ray_x;
		logic signed [31:0] ray_y;
		logic signed [31:0] ray_z;
		logic signed [31:0] disc_x;
		logic signed [31:0] disc_y;
		logic signed [31:0] disc_z;
		logic [30:0]        disc_radius;
		logic [7:0]         disc_index;
		logic               last_disc;
	} item_t;

	typedef struct packed {
		logic               hit;
		logic [7:0]         hit_index;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctrl_t;

endpackage

/* rtl/rdsh_if.sv */
// ----------------------------------------------------------------------------
// rdsh_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface rdsh_item_if;
	import rdsh_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rdsh_result_if;
	import rdsh_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/rdsh_mul.sv */
// ----------------------------------------------------------------------------
// rdsh_mul
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle while step is set.
// ----------------------------------------------------------------------------
module rdsh_mul (
	input  logic                          clk,
	input  rdsh_pkg::mul_ctrl_t           ctrl,
	input  logic [rdsh_pkg::MUL_A_W-1:0]  a,
	input  logic [rdsh_pkg::MUL_B_W-1:0]  b,
	output logic [rdsh_pkg::MUL_P_W-1:0]  prod
);
	import rdsh_pkg::*;

	logic [MUL_P_W-1:0] acc_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_B_W:0]   sum;

	assign sum = {1'b0, acc_q[MUL_P_W-1:MUL_A_W]} + (acc_q[0] ? {1'b0, b_q} : '0);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= {{MUL_B_W{1'b0}}, a};
			b_q   <= b;
		end else if (ctrl.step) begin
			acc_q <= {sum, acc_q[MUL_A_W-1:1]};
		end
	end

	assign prod = acc_q;

endmodule

/* rtl/ray_disc_shield_hit_scan.sv */
// ----------------------------------------------------------------------------
// ray_disc_shield_hit_scan
// Streams shields of a query, finds the first disc that the line crosses.
// A tested item goes through a serial divide, a serial multiply and a serial
// square step; the divide is skipped on overflow, the square step when the point
// lies outside the disc's box. Items after a hit, or with a parallel line, skip
// all three. A result is given only for the last disc of a query, and it waits
// while the previous result is not taken. One item is in work at a time.
// Reset clears the hit latch, the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module ray_disc_shield_hit_scan (
	input  logic        clk,
	input  logic        arst_n,
	rdsh_item_if.sink   item,
	rdsh_result_if.source result
);
	import rdsh_pkg::*;

	localparam int NW = 33 + FRAC_BITS;
	localparam int SW = 67 - FRAC_BITS;
	localparam logic signed [SW-1:0] MAXV = {{(SW-32){1'b0}}, 32'h7FFF_FFFF};
	localparam logic signed [SW-1:0] MINV = {{(SW-32){1'b1}}, 32'h8000_0000};

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_DIV, ST_LOADM, ST_MUL,
		ST_ALONG, ST_CHK, ST_SQ, ST_TEST, ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	item_t              it_q;
	logic               neg_t_q, ovf_q, neg_x_q, neg_z_q;
	logic [32:0]        rem_q, dm_q;
	logic [31:0]        dvd_q;
	logic signed [31:0] x_q, z_q;
	logic               found_q;
	logic [7:0]         found_index_q;
	logic signed [31:0] found_x_q, found_y_q, found_z_q;
	logic               out_valid_q;
	result_t            out_q;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		if (v > MAXV) return 32'sh7FFF_FFFF;
		if (v < MINV) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? 33'(-v) : v;
	endfunction

	function automatic logic signed [SW-1:0] along(input logic signed [31:0] p0,
			input logic [MUL_P_W-1:0] prod, input logic neg);
		logic [SW-1:0] m;
		m = {2'b0, prod[MUL_P_W-1:FRAC_BITS]};
		return {{(SW-32){p0[31]}}, p0} + (neg ? SW'(-m) : m);
	endfunction

	// Plane crossing parameter setup.
	logic [32:0] d_s, n_s, dm, nm;
	logic        d_zero, div_ovf;
	logic [NW-1:0] dvd_full;
	assign d_s      = {it_q.ray_y[31], it_q.ray_y} - {it_q.atom_y[31], it_q.atom_y};
	assign n_s      = {it_q.disc_y[31], it_q.disc_y} - {it_q.atom_y[31], it_q.atom_y};
	assign dm       = mag33(d_s);
	assign nm       = mag33(n_s);
	assign d_zero   = (d_s == '0);
	assign div_ovf  = {32'b0, nm} >= (65'(dm) << (32 - FRAC_BITS));
	assign dvd_full = {nm, {FRAC_BITS{1'b0}}};

	// Restoring divide step.
	logic [33:0] rem_sh, rem_sub;
	logic        q_bit;
	assign rem_sh  = {rem_q, dvd_q[31]};
	assign rem_sub = rem_sh - {1'b0, dm_q};
	assign q_bit   = rem_sh >= {1'b0, dm_q};

	// Saturated magnitude of the crossing parameter.
	logic [31:0] t_mag;
	always_comb begin
		if (ovf_q) begin
			t_mag = neg_t_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (neg_t_q) begin
			t_mag = (dvd_q > 32'h8000_0000) ? 32'h8000_0000 : dvd_q;
		end else begin
			t_mag = (dvd_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q;
		end
	end

	logic [32:0] diffx, diffz;
	assign diffx = {it_q.ray_x[31], it_q.ray_x} - {it_q.atom_x[31], it_q.atom_x};
	assign diffz = {it_q.ray_z[31], it_q.ray_z} - {it_q.atom_z[31], it_q.atom_z};

	// Distance from the disc centre.
	logic [32:0] ex, ez, mx, mz;
	logic        in_box;
	assign ex     = {x_q[31], x_q} - {it_q.disc_x[31], it_q.disc_x};
	assign ez     = {z_q[31], z_q} - {it_q.disc_z[31], it_q.disc_z};
	assign mx     = mag33(ex);
	assign mz     = mag33(ez);
	assign in_box = (mx <= {2'b0, it_q.disc_radius}) && (mz <= {2'b0, it_q.disc_radius});

	mul_ctrl_t          mul_ctrl;
	logic [MUL_A_W-1:0] mxa, mza;
	logic [MUL_B_W-1:0] mxb, mzb;
	logic [MUL_P_W-1:0] prod_x, prod_z, prod_r;

	always_comb begin
		mul_ctrl.load = (state_q == ST_LOADM) || (state_q == ST_CHK && in_box);
		mul_ctrl.step = (state_q == ST_MUL) || (state_q == ST_SQ);
		if (state_q == ST_LOADM) begin
			mxa = t_mag;
			mza = t_mag;
			mxb = mag33(diffx);
			mzb = mag33(diffz);
		end else begin
			mxa = mx[31:0];
			mza = mz[31:0];
			mxb = mx;
			mzb = mz;
		end
	end

	rdsh_mul u_mul_x (.clk(clk), .ctrl(mul_ctrl), .a(mxa), .b(mxb), .prod(prod_x));
	rdsh_mul u_mul_z (.clk(clk), .ctrl(mul_ctrl), .a(mza), .b(mzb), .prod(prod_z));
	rdsh_mul u_mul_r (.clk(clk), .ctrl(mul_ctrl), .a({1'b0, it_q.disc_radius}),
		.b({2'b0, it_q.disc_radius}), .prod(prod_r));

	logic is_hit;
	assign is_hit = ({1'b0, prod_x} + {1'b0, prod_z}) <= {1'b0, prod_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			found_q       <= 1'b0;
			found_index_q <= '0;
			found_x_q     <= '0;
			found_y_q     <= '0;
			found_z_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && !(state_q == ST_DONE && it_q.last_disc))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						it_q    <= item.data;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					neg_t_q <= d_s[32] ^ n_s[32];
					ovf_q   <= div_ovf;
					cnt_q   <= '0;
					rem_q   <= 33'(dvd_full[NW-1:32]);
					dvd_q   <= dvd_full[31:0];
					dm_q    <= dm;
					if (found_q || d_zero) state_q <= ST_DONE;
					else if (div_ovf) state_q <= ST_LOADM;
					else state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= q_bit ? rem_sub[32:0] : rem_sh[32:0];
					dvd_q <= {dvd_q[30:0], q_bit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_A_W - 1)) state_q <= ST_LOADM;
				end
				ST_LOADM: begin
					neg_x_q <= neg_t_q ^ diffx[32];
					neg_z_q <= neg_t_q ^ diffz[32];
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_A_W - 1)) state_q <= ST_ALONG;
				end
				ST_ALONG: begin
					x_q     <= sat32(along(it_q.atom_x, prod_x, neg_x_q));
					z_q     <= sat32(along(it_q.atom_z, prod_z, neg_z_q));
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					cnt_q   <= '0;
					state_q <= in_box ? ST_SQ : ST_DONE;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_A_W - 1)) state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (is_hit) begin
						found_q       <= 1'b1;
						found_index_q <= it_q.disc_index;
						found_x_q     <= x_q;
						found_y_q     <= it_q.disc_y;
						found_z_q     <= z_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!it_q.last_disc) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || result.ready) begin
						out_valid_q     <= 1'b1;
						out_q.hit       <= found_q;
						out_q.hit_index <= found_index_q;
						out_q.hit_x     <= found_x_q;
						out_q.hit_y     <= found_y_q;
						out_q.hit_z     <= found_z_q;
						found_q         <= 1'b0;
						found_index_q   <= '0;
						found_x_q       <= '0;
						found_y_q       <= '0;
						found_z_q       <= '0;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item.ready   = arst_n && (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule
